/* hdl/lfac_pkg.sv */
package lfac_pkg;

    localparam int LEVEL_W = 16;
    localparam int SPEED_W = 8;
    localparam int COUNT_W = 9;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SENSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEER = 2'd2;
    localparam logic [MODE_W-1:0] MODE_AVOID = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH      = 2'd2;

    localparam logic [LEVEL_W-1:0] LINE_THRESHOLD_RST = 16'd5000;
    localparam logic [LEVEL_W-1:0] BAND_LOW_RST       = 16'd2062;
    localparam logic [LEVEL_W-1:0] BAND_HIGH_RST      = 16'd6100;

    localparam logic [COUNT_W-1:0] AVOID_LOAD          = 9'd450;
    localparam logic [COUNT_W-1:0] AVOID_REVERSE_ABOVE = 9'd429;
    localparam logic [COUNT_W-1:0] AVOID_PIVOT_ABOVE   = 9'd353;
    localparam logic [COUNT_W-1:0] AVOID_ARC_ABOVE     = 9'd60;

    localparam logic signed [SPEED_W-1:0] SPD_FULL      = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPD_FULL_REV  = -8'sd100;
    localparam logic signed [SPEED_W-1:0] SPD_BACK_L    = -8'sd6;
    localparam logic signed [SPEED_W-1:0] SPD_BACK_R    = -8'sd10;
    localparam logic signed [SPEED_W-1:0] SPD_TURN_FAST = 8'sd40;
    localparam logic signed [SPEED_W-1:0] SPD_TURN_SLOW = 8'sd5;
    localparam logic signed [SPEED_W-1:0] SPD_PIVOT     = 8'sd80;
    localparam logic signed [SPEED_W-1:0] SPD_STOP      = 8'sd0;
    localparam logic signed [SPEED_W-1:0] SPD_ARC_L     = 8'sd7;
    localparam logic signed [SPEED_W-1:0] SPD_ARC_R     = 8'sd30;

    typedef struct packed {
        logic               left_bump;
        logic               right_bump;
        logic [LEVEL_W-1:0] ground_level;
    } in_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic [MODE_W-1:0]         mode_now;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] line_threshold;
        logic [LEVEL_W-1:0] band_low;
        logic [LEVEL_W-1:0] band_high;
    } cfg_t;

endpackage

/* hdl/lfac_cfg_regs.sv */
module lfac_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [lfac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfac_pkg::LEVEL_W-1:0]   cfg_data,
    output lfac_pkg::cfg_t                 cfg
);
    import lfac_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LINE_THRESHOLD: cfg_next.line_threshold = cfg_data;
                REG_BAND_LOW:       cfg_next.band_low       = cfg_data;
                REG_BAND_HIGH:      cfg_next.band_high      = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_threshold <= LINE_THRESHOLD_RST;
            cfg_reg.band_low       <= BAND_LOW_RST;
            cfg_reg.band_high      <= BAND_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/lfac_step.sv */
module lfac_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  lfac_pkg::cfg_t      cfg,
    input  lfac_pkg::in_item_t  item,
    output lfac_pkg::out_item_t result
);
    import lfac_pkg::*;

    logic [MODE_W-1:0]         mode_reg;
    logic [MODE_W-1:0]         mode_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic signed [SPEED_W-1:0] left_reg;
    logic signed [SPEED_W-1:0] left_next;
    logic signed [SPEED_W-1:0] right_reg;
    logic signed [SPEED_W-1:0] right_next;

    logic bump;
    logic line_seen;
    logic in_band;

    assign bump      = item.left_bump | item.right_bump;
    assign line_seen = item.ground_level > cfg.line_threshold;
    assign in_band   = (item.ground_level > cfg.band_low) &&
                       (item.ground_level < cfg.band_high);

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        left_next  = left_reg;
        right_next = right_reg;
        case (mode_reg)
            MODE_CHECK:
            begin
                mode_next = MODE_SENSE;
            end
            MODE_SENSE:
            begin
                if (bump)
                begin
                    left_next  = SPD_BACK_L;
                    right_next = SPD_BACK_R;
                    count_next = AVOID_LOAD;
                    mode_next  = MODE_AVOID;
                end
                else
                begin
                    mode_next = MODE_STEER;
                end
            end
            MODE_STEER:
            begin
                if (in_band)
                begin
                    left_next  = SPD_FULL;
                    right_next = SPD_FULL;
                end
                else if (line_seen)
                begin
                    left_next  = SPD_TURN_FAST;
                    right_next = SPD_TURN_SLOW;
                end
                else
                begin
                    left_next  = SPD_TURN_SLOW;
                    right_next = SPD_TURN_FAST;
                end
                mode_next = MODE_CHECK;
            end
            default:
            begin
                if (count_reg > AVOID_REVERSE_ABOVE)
                begin
                    left_next  = SPD_FULL_REV;
                    right_next = SPD_FULL_REV;
                end
                else if (count_reg > AVOID_PIVOT_ABOVE)
                begin
                    left_next  = SPD_PIVOT;
                    right_next = SPD_STOP;
                end
                else if (count_reg > AVOID_ARC_ABOVE)
                begin
                    left_next  = SPD_ARC_L;
                    right_next = SPD_ARC_R;
                end

                if ((count_reg <= AVOID_PIVOT_ABOVE) && (count_reg > AVOID_ARC_ABOVE)
                    && line_seen)
                begin
                    count_next = '0;
                    mode_next  = MODE_CHECK;
                end
                else if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    mode_next = MODE_CHECK;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_CHECK;
            count_reg <= '0;
            left_reg  <= SPD_STOP;
            right_reg <= SPD_STOP;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign result.left_speed  = left_next;
    assign result.right_speed = right_next;
    assign result.mode_now    = mode_next;

endmodule

/* hdl/line_follow_avoid_controller_core.sv */
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------
// in       | in_valid / in_stall    | in_data  (bumpers, ground level)
// out      | out_valid / out_stall  | out_data (wheel speeds, mode)
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Input transfer to result: input register, then the mode
// update logic loads the result register together with the controller state.
// One item per cycle while out_stall is low; the state loop is not pipelined.
// rst_n clears mode, count, drives, pipeline valids and loads register defaults.
// out_stall holds the result register and backs up into in_stall only when
// both stages are full.
module line_follow_avoid_controller_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lfac_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lfac_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfac_pkg::LEVEL_W-1:0]   cfg_data
);
    import lfac_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_vld_reg;
    out_item_t result;
    out_item_t res_reg;
    logic      res_vld_reg;
    logic      advance;
    logic      in_take;

    assign cfg_ready = 1'b1;

    lfac_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfac_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (result)
    );

    assign advance  = item_vld_reg && (!res_vld_reg || !out_stall);
    assign in_stall = item_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                item_vld_reg <= 1'b1;
            else if (advance)
                item_vld_reg <= 1'b0;

            if (advance)
                res_vld_reg <= 1'b1;
            else if (!out_stall)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_data;
        if (advance)
            res_reg <= result;
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

endmodule
